[rtl/core/assert_macros.svh]
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mfd_pkg.sv]
// package: types, codes and the frame decode function of the multimeter frame decoder
`default_nettype none

package mfd_pkg;

    // frame geometry
    localparam int KEPT_BYTES      = 7;
    localparam int KIDX_W          = $clog2(KEPT_BYTES);
    localparam int MAX_FRAME_BYTES = 16;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // function byte codes
    localparam logic [7:0] FN_VOLT  = 8'h3B;
    localparam logic [7:0] FN_UA    = 8'h3D;
    localparam logic [7:0] FN_MA    = 8'h39;
    localparam logic [7:0] FN_AMP   = 8'h3F;
    localparam logic [7:0] FN_OHM   = 8'h33;
    localparam logic [7:0] FN_CONT  = 8'h35;
    localparam logic [7:0] FN_DIODE = 8'h31;
    localparam logic [7:0] FN_FREQ  = 8'h32;
    localparam logic [7:0] FN_CAP   = 8'h36;
    localparam logic [7:0] FN_TEMP  = 8'h34;

    // status bits
    localparam int ST_OL_BIT    = 0;
    localparam int ST_SIGN_BIT  = 2;
    localparam int ST_JUDGE_BIT = 3;

    // frame positions
    localparam int POS_RANGE  = 0;
    localparam int POS_DIG1   = 1;
    localparam int POS_DIG2   = 2;
    localparam int POS_DIG3   = 3;
    localparam int POS_DIG4   = 4;
    localparam int POS_FUNC   = 5;
    localparam int POS_STATUS = 6;

    typedef enum logic [2:0] {
        PX_NONE  = 3'd0,
        PX_MILLI = 3'd1,
        PX_MICRO = 3'd2,
        PX_KILO  = 3'd3,
        PX_MEGA  = 3'd4,
        PX_NANO  = 3'd5
    } t_prefix;

    typedef enum logic [3:0] {
        UNIT_NONE = 4'd0,
        UNIT_VOLT = 4'd1,
        UNIT_AMP  = 4'd2,
        UNIT_OHM  = 4'd3,
        UNIT_HZ   = 4'd4,
        UNIT_RPM  = 4'd5,
        UNIT_FARAD = 4'd6,
        UNIT_DEGC = 4'd7,
        UNIT_DEGF = 4'd8
    } t_unit;

    typedef enum logic [3:0] {
        MODE_NONE  = 4'd0,
        MODE_VOLTS = 4'd1,
        MODE_AMPS  = 4'd2,
        MODE_RES   = 4'd3,
        MODE_CONT  = 4'd4,
        MODE_DIODE = 4'd5,
        MODE_FREQ  = 4'd6,
        MODE_RPM   = 4'd7,
        MODE_CAP   = 4'd8,
        MODE_TEMP  = 4'd9
    } t_mode;

    // channel payloads
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic signed [15:0] reading_value;
        logic [1:0]         decimal_places;
        logic               overload;
        logic [2:0]         prefix_code;
        logic [3:0]         unit_code;
        logic [3:0]         mode_code;
    } t_reading;

    // kept frame bytes, position 0 in the low byte
    typedef logic [KEPT_BYTES-1:0][7:0] t_frame;

    // status from the frame store towards the decode stage
    typedef struct packed {
        logic pending;
    } t_store_stat;

    // decode one frame; decimal_places carries the updated decimal count
    function automatic t_reading decode_frame(input t_frame fb, input logic [1:0] last_dec);
        t_reading   d;
        logic [3:0] r;
        logic [7:0] st;
        logic [14:0] mag;
        d = '0;
        r = fb[POS_RANGE][3:0];
        st = fb[POS_STATUS];
        d.decimal_places = last_dec;
        d.prefix_code    = PX_NONE;
        d.unit_code      = UNIT_NONE;
        d.mode_code      = MODE_NONE;
        d.overload       = st[ST_OL_BIT];

        // function and range tables
        case (fb[POS_FUNC])
            FN_VOLT: begin
                d.unit_code = UNIT_VOLT;
                d.mode_code = MODE_VOLTS;
                case (r)
                    4'd0: begin d.decimal_places = 2'd1; d.prefix_code = PX_MILLI; end
                    4'd1: d.decimal_places = 2'd3;
                    4'd2: d.decimal_places = 2'd2;
                    4'd3: d.decimal_places = 2'd1;
                    4'd4: d.decimal_places = 2'd0;
                    default: ;
                endcase
            end
            FN_UA: begin
                // micro-amp code reports milli, as the meter defines it
                d.unit_code   = UNIT_AMP;
                d.mode_code   = MODE_AMPS;
                d.prefix_code = PX_MILLI;
                case (r)
                    4'd0: d.decimal_places = 2'd2;
                    4'd1: d.decimal_places = 2'd1;
                    default: ;
                endcase
            end
            FN_MA: begin
                // milli-amp code reports micro
                d.unit_code   = UNIT_AMP;
                d.mode_code   = MODE_AMPS;
                d.prefix_code = PX_MICRO;
                case (r)
                    4'd0: d.decimal_places = 2'd1;
                    4'd1: d.decimal_places = 2'd0;
                    default: ;
                endcase
            end
            FN_AMP: begin
                d.unit_code = UNIT_AMP;
                d.mode_code = MODE_AMPS;
            end
            FN_OHM: begin
                d.unit_code = UNIT_OHM;
                d.mode_code = MODE_RES;
                case (r)
                    4'd0: d.decimal_places = 2'd1;
                    4'd1: begin d.decimal_places = 2'd3; d.prefix_code = PX_KILO; end
                    4'd2: begin d.decimal_places = 2'd2; d.prefix_code = PX_KILO; end
                    4'd3: begin d.decimal_places = 2'd1; d.prefix_code = PX_KILO; end
                    4'd4: begin d.decimal_places = 2'd3; d.prefix_code = PX_MEGA; end
                    4'd5: begin d.decimal_places = 2'd2; d.prefix_code = PX_MEGA; end
                    default: ;
                endcase
            end
            FN_CONT: begin
                d.unit_code      = UNIT_OHM;
                d.mode_code      = MODE_CONT;
                d.decimal_places = 2'd1;
            end
            FN_DIODE: begin
                d.unit_code      = UNIT_VOLT;
                d.mode_code      = MODE_DIODE;
                d.decimal_places = 2'd3;
            end
            FN_FREQ: begin
                if (st[ST_JUDGE_BIT]) begin
                    d.unit_code = UNIT_HZ;
                    d.mode_code = MODE_FREQ;
                    case (r)
                        4'd0: begin d.decimal_places = 2'd3; d.prefix_code = PX_KILO; end
                        4'd1: begin d.decimal_places = 2'd2; d.prefix_code = PX_KILO; end
                        4'd2: begin d.decimal_places = 2'd1; d.prefix_code = PX_KILO; end
                        4'd3: begin d.decimal_places = 2'd3; d.prefix_code = PX_MEGA; end
                        4'd4: begin d.decimal_places = 2'd2; d.prefix_code = PX_MEGA; end
                        4'd5: begin d.decimal_places = 2'd1; d.prefix_code = PX_MEGA; end
                        default: ;
                    endcase
                end else begin
                    d.unit_code = UNIT_RPM;
                    d.mode_code = MODE_RPM;
                    case (r)
                        4'd0: begin d.decimal_places = 2'd2; d.prefix_code = PX_KILO; end
                        4'd1: begin d.decimal_places = 2'd1; d.prefix_code = PX_KILO; end
                        4'd2: begin d.decimal_places = 2'd3; d.prefix_code = PX_MEGA; end
                        4'd3: begin d.decimal_places = 2'd2; d.prefix_code = PX_MEGA; end
                        4'd4: begin d.decimal_places = 2'd1; d.prefix_code = PX_MEGA; end
                        4'd5: begin d.decimal_places = 2'd0; d.prefix_code = PX_MEGA; end
                        default: ;
                    endcase
                end
            end
            FN_CAP: begin
                d.unit_code = UNIT_FARAD;
                d.mode_code = MODE_CAP;
                case (r)
                    4'd0: begin d.decimal_places = 2'd3; d.prefix_code = PX_NANO; end
                    4'd1: begin d.decimal_places = 2'd2; d.prefix_code = PX_NANO; end
                    4'd2: begin d.decimal_places = 2'd1; d.prefix_code = PX_NANO; end
                    4'd3: begin d.decimal_places = 2'd3; d.prefix_code = PX_MICRO; end
                    4'd4: begin d.decimal_places = 2'd2; d.prefix_code = PX_MICRO; end
                    4'd5: begin d.decimal_places = 2'd1; d.prefix_code = PX_MICRO; end
                    4'd6: begin d.decimal_places = 2'd3; d.prefix_code = PX_MILLI; end
                    4'd7: begin d.decimal_places = 2'd2; d.prefix_code = PX_MILLI; end
                    default: ;
                endcase
            end
            FN_TEMP: begin
                d.mode_code = MODE_TEMP;
                d.unit_code = st[ST_JUDGE_BIT] ? UNIT_DEGC : UNIT_DEGF;
            end
            default: ;
        endcase

        // weighted digit sum, then sign
        mag = 15'(fb[POS_DIG1][3:0]) * 15'd1000
            + 15'(fb[POS_DIG2][3:0]) * 15'd100
            + 15'(fb[POS_DIG3][3:0]) * 15'd10
            + 15'(fb[POS_DIG4][3:0]);
        d.reading_value = st[ST_SIGN_BIT] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mfd_stream_if.sv]
// valid/ready channel interface carrying one item of type T
`default_nettype none

interface mfd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/mfd_frame_store.sv]
// frame store: keeps frame bytes and position, flags a complete frame for decode
`default_nettype none

`include "assert_macros.svh"

module mfd_frame_store import mfd_pkg::*; #(
    parameter int P_MAX_FRAME_BYTES = MAX_FRAME_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mfd_stream_if.sink       i_rx,
    input  wire logic        i_out_free,
    output t_store_stat      o_stat,
    output t_frame           o_frame
);
    localparam int PW = $clog2(P_MAX_FRAME_BYTES);

    t_frame        r_frame, n_frame;
    logic [PW-1:0] r_pos,   n_pos;
    logic          r_pend,  n_pend;
    logic          w_accept;
    logic          w_end;

    // a pending frame blocks new bytes until the decode stage takes it
    assign i_rx.ready = !r_pend || i_out_free;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_end      = (i_rx.data.rx_byte == NEWLINE_BYTE)
                     || (r_pos == PW'(P_MAX_FRAME_BYTES - 1));

    // store, position and pending flag
    always_comb begin
        n_frame = r_frame;
        n_pos   = r_pos;
        n_pend  = r_pend && !i_out_free;
        if (w_accept) begin
            if (r_pos < PW'(KEPT_BYTES)) begin
                n_frame[r_pos[KIDX_W-1:0]] = i_rx.data.rx_byte;
            end
            n_pos  = w_end ? '0 : r_pos + PW'(1);
            n_pend = w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_pos   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_frame <= n_frame;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
        end
    end

    assign o_stat.pending = r_pend;
    assign o_frame        = r_frame;

    // checks
    `ASSERT_NEXT(a_pend_holds, i_clk, i_rst_n, r_pend && !i_out_free,
        r_pend && $stable(r_pos) && $stable(r_frame), "pending frame changed while stalled")
    `ASSERT_NEXT(a_newline_ends, i_clk, i_rst_n,
        w_accept && (i_rx.data.rx_byte == NEWLINE_BYTE),
        r_pend && (r_pos == '0), "newline did not end the frame")
    `ASSERT_NEXT(a_limit_ends, i_clk, i_rst_n,
        w_accept && (r_pos == PW'(P_MAX_FRAME_BYTES - 1)),
        r_pend && (r_pos == '0), "byte limit did not end the frame")
endmodule

`default_nettype wire

[rtl/core/mfd_decode_stage.sv]
// decode stage: frame decode, decimal count, mode enable and result register
`default_nettype none

`include "assert_macros.svh"

module mfd_decode_stage import mfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire t_store_stat i_stat,
    input  wire t_frame      i_frame,
    output logic             o_out_free,
    mfd_stream_if.source     o_reading
);
    logic       r_mode_en;
    logic [1:0] r_dec;
    logic       r_valid, n_valid;
    t_reading   r_out;
    t_reading   w_dec;
    logic       w_take;

    // result register frees when empty or being taken
    assign o_out_free = !r_valid || o_reading.ready;
    assign w_take     = i_stat.pending && o_out_free;

    // decode, mode code masked unless enabled
    always_comb begin
        w_dec = decode_frame(i_frame, r_dec);
        if (!r_mode_en) begin
            w_dec.mode_code = MODE_NONE;
        end
    end

    always_comb begin
        n_valid = w_take || (r_valid && !o_reading.ready);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_en <= 1'b0;
            r_dec     <= 2'd0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode_en <= i_cfg_wdata;
            end
            if (w_take) begin
                r_dec <= w_dec.decimal_places;
            end
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_dec;
        end
    end

    assign o_reading.valid = r_valid;
    assign o_reading.data  = r_out;

    // checks
    `ASSERT_NEXT(a_take_loads, i_clk, i_rst_n, w_take, r_valid,
        "decoded frame not presented")
    `ASSERT_NEXT(a_dec_stable, i_clk, i_rst_n, !w_take, $stable(r_dec),
        "decimal count changed without a frame")
    `ASSERT_NEXT(a_dec_matches, i_clk, i_rst_n, w_take, r_out.decimal_places == r_dec,
        "reported decimals differ from held count")
endmodule

`default_nettype wire

[rtl/core/multimeter_frame_decoder.sv]
// top level of the multimeter serial frame decoder
//
//  channel    dir  payload                                      handshake
//  i_rx       in   rx_byte[7:0]                                 valid/ready
//  o_reading  out  reading_value, decimal_places, overload,     valid/ready
//                  prefix_code, unit_code, mode_code
//  i_cfg_*    in   mode enable (i_cfg_wdata)                    write enable
//
//  one byte is taken per cycle unless a finished frame waits on a held reading;
//  a frame-ending byte loads the frame store, from which its reading is registered
//  the decode itself is one pass of table logic and a constant-weight digit sum
//  synchronous active-low reset clears the kept bytes, position, decimal count
//  and the mode enable; no clearing pass
//  while a reading is stalled, bytes that do not end a frame are still taken;
//  a second frame end waits in the frame store and holds off input
`default_nettype none

module multimeter_frame_decoder import mfd_pkg::*; #(
    parameter int P_MAX_FRAME_BYTES = MAX_FRAME_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    mfd_stream_if.sink       i_rx,
    mfd_stream_if.source     o_reading
);
    t_store_stat w_stat;
    t_frame      w_frame;
    logic        w_out_free;

    // byte capture and frame end detection
    mfd_frame_store #(
        .P_MAX_FRAME_BYTES (P_MAX_FRAME_BYTES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_out_free (w_out_free),
        .o_stat     (w_stat),
        .o_frame    (w_frame)
    );

    // reading decode and result register
    mfd_decode_stage u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (w_stat),
        .i_frame     (w_frame),
        .o_out_free  (w_out_free),
        .o_reading   (o_reading)
    );
endmodule

`default_nettype wire

[sim/multimeter_frame_decoder_tb.sv]
// self-checking testbench for the multimeter frame decoder against a local decode
module multimeter_frame_decoder_tb import mfd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // range tables, index 0 first
    localparam logic [0:4][1:0] VOLT_DEC = {2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam logic [0:1][1:0] UA_DEC   = {2'd2, 2'd1};
    localparam logic [0:1][1:0] MA_DEC   = {2'd1, 2'd0};
    localparam logic [0:5][1:0] OHM_DEC  = {2'd1, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2};
    localparam logic [0:5][2:0] OHM_PX   = {PX_NONE, PX_KILO, PX_KILO, PX_KILO, PX_MEGA, PX_MEGA};
    localparam logic [0:5][1:0] HZ_DEC   = {2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd1};
    localparam logic [0:5][2:0] HZ_PX    = {PX_KILO, PX_KILO, PX_KILO, PX_MEGA, PX_MEGA, PX_MEGA};
    localparam logic [0:5][1:0] RPM_DEC  = {2'd2, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
    localparam logic [0:5][2:0] RPM_PX   = {PX_KILO, PX_KILO, PX_MEGA, PX_MEGA, PX_MEGA, PX_MEGA};
    localparam logic [0:7][1:0] CAP_DEC  = {2'd3, 2'd2, 2'd1, 2'd3, 2'd2, 2'd1, 2'd3, 2'd2};
    localparam logic [0:7][2:0] CAP_PX   = {PX_NANO, PX_NANO, PX_NANO, PX_MICRO, PX_MICRO,
                                            PX_MICRO, PX_MILLI, PX_MILLI};

    localparam int HOLD_CYCLES = 80;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 235;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;

    mfd_stream_if #(.T(t_rx_item)) rx_ch ();
    mfd_stream_if #(.T(t_reading)) rd_ch ();

    multimeter_frame_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_reading   (rd_ch)
    );

    // local copy of the decoder state
    logic [7:0] frame_store [KEPT_BYTES];
    int         frame_pos   = 0;
    logic [1:0] held_dec    = 2'd0;
    logic       mode_en_q   = 1'b0;

    logic [7:0] byte_q [$];
    t_reading   readings_q [$];
    t_reading   want_rd;

    int unsigned n_pushed   = 0;
    int unsigned n_taken    = 0;
    int unsigned n_err      = 0;
    int unsigned hold_reqs  = 0;
    int unsigned holds_done = 0;
    int unsigned hold_left  = 0;
    int unsigned rx_gap     = 0;
    int unsigned rd_gap     = 0;
    logic        rx_fire    = 1'b0;
    logic        rx_idle_on = 1'b1;
    logic        rd_idle_on = 1'b1;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // decode the kept bytes into one reading, updating the held decimal count
    function automatic t_reading decode_reading();
        t_reading    rd;
        logic [3:0]  rng;
        logic [7:0]  stat;
        logic [15:0] mag;
        rd   = '0;
        rng  = frame_store[POS_RANGE][3:0];
        stat = frame_store[POS_STATUS];
        case (frame_store[POS_FUNC])
            FN_VOLT: begin
                rd.unit_code = UNIT_VOLT;
                rd.mode_code = MODE_VOLTS;
                if (rng < 5) begin
                    held_dec = VOLT_DEC[rng];
                    if (rng == 0) rd.prefix_code = PX_MILLI;
                end
            end
            FN_UA: begin
                // micro-amp code reports milli
                rd.unit_code   = UNIT_AMP;
                rd.mode_code   = MODE_AMPS;
                rd.prefix_code = PX_MILLI;
                if (rng < 2) held_dec = UA_DEC[rng];
            end
            FN_MA: begin
                rd.unit_code   = UNIT_AMP;
                rd.mode_code   = MODE_AMPS;
                rd.prefix_code = PX_MICRO;
                if (rng < 2) held_dec = MA_DEC[rng];
            end
            FN_AMP: begin
                rd.unit_code = UNIT_AMP;
                rd.mode_code = MODE_AMPS;
            end
            FN_OHM: begin
                rd.unit_code = UNIT_OHM;
                rd.mode_code = MODE_RES;
                if (rng < 6) begin
                    held_dec       = OHM_DEC[rng];
                    rd.prefix_code = OHM_PX[rng];
                end
            end
            FN_CONT: begin
                rd.unit_code = UNIT_OHM;
                rd.mode_code = MODE_CONT;
                held_dec     = 2'd1;
            end
            FN_DIODE: begin
                rd.unit_code = UNIT_VOLT;
                rd.mode_code = MODE_DIODE;
                held_dec     = 2'd3;
            end
            FN_FREQ: begin
                if (stat[ST_JUDGE_BIT]) begin
                    rd.unit_code = UNIT_HZ;
                    rd.mode_code = MODE_FREQ;
                    if (rng < 6) begin
                        held_dec       = HZ_DEC[rng];
                        rd.prefix_code = HZ_PX[rng];
                    end
                end else begin
                    rd.unit_code = UNIT_RPM;
                    rd.mode_code = MODE_RPM;
                    if (rng < 6) begin
                        held_dec       = RPM_DEC[rng];
                        rd.prefix_code = RPM_PX[rng];
                    end
                end
            end
            FN_CAP: begin
                rd.unit_code = UNIT_FARAD;
                rd.mode_code = MODE_CAP;
                if (rng < 8) begin
                    held_dec       = CAP_DEC[rng];
                    rd.prefix_code = CAP_PX[rng];
                end
            end
            FN_TEMP: begin
                rd.mode_code = MODE_TEMP;
                rd.unit_code = stat[ST_JUDGE_BIT] ? UNIT_DEGC : UNIT_DEGF;
            end
            default: ;
        endcase

        // weighted digit sum, negated on the sign bit
        mag = 16'(frame_store[POS_DIG1][3:0]) * 16'd1000
            + 16'(frame_store[POS_DIG2][3:0]) * 16'd100
            + 16'(frame_store[POS_DIG3][3:0]) * 16'd10
            + 16'(frame_store[POS_DIG4][3:0]);
        rd.reading_value  = stat[ST_SIGN_BIT] ? 16'd0 - mag : mag;
        rd.decimal_places = held_dec;
        rd.overload       = stat[ST_OL_BIT];
        if (!mode_en_q) rd.mode_code = MODE_NONE;
        return rd;
    endfunction

    // store one accepted byte and queue a reading when it ends the frame
    function automatic void absorb_byte(input logic [7:0] b);
        if (frame_pos < KEPT_BYTES) frame_store[frame_pos] = b;
        if (b == NEWLINE_BYTE) begin
            frame_pos = 0;
            readings_q.push_back(decode_reading());
        end else begin
            frame_pos++;
            if (frame_pos >= MAX_FRAME_BYTES) begin
                frame_pos = 0;
                readings_q.push_back(decode_reading());
            end
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] b);
        return (b == NEWLINE_BYTE) ? b ^ 8'h01 : b;
    endfunction

    function automatic logic [7:0] rand_plain();
        return plain_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [7:0] pick_function();
        case ($urandom_range(0, 9))
            0: return FN_VOLT;
            1: return FN_UA;
            2: return FN_MA;
            3: return FN_AMP;
            4: return FN_OHM;
            5: return FN_CONT;
            6: return FN_DIODE;
            7: return FN_FREQ;
            8: return FN_CAP;
            default: return FN_TEMP;
        endcase
    endfunction

    function automatic logic [3:0] upper_nibble();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'h3;
    endfunction

    task automatic put(input logic [7:0] b);
        byte_q.push_back(b);
        n_pushed++;
    endtask

    // well-formed frame with random content
    task automatic send_reading();
        logic [3:0] nib;
        int unsigned n_extra;
        nib = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
        put(plain_byte({upper_nibble(), nib}));
        repeat (4) begin
            nib = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 9));
            put(plain_byte({upper_nibble(), nib}));
        end
        put(($urandom_range(0, 99) < 85) ? pick_function() : rand_plain());
        put(plain_byte({upper_nibble(), 4'($urandom_range(0, 15))}));
        n_extra = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 2);
        repeat (n_extra) put(rand_plain());
        put(NEWLINE_BYTE);
    endtask

    // frame cut short, so older bytes stay in the upper positions
    task automatic send_short();
        repeat ($urandom_range(0, 6)) put(rand_plain());
        put(NEWLINE_BYTE);
    endtask

    // fully random bytes, newlines included
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
        put(NEWLINE_BYTE);
    endtask

    // no newline for long enough to hit the frame byte limit
    task automatic send_overrun();
        repeat ($urandom_range(16, 24)) put(rand_plain());
        put(NEWLINE_BYTE);
    endtask

    task automatic wait_idle();
        while (n_taken != n_pushed || readings_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write and handshake style for the next stretch of items
    task automatic begin_phase(input logic show, input logic rx_idle, input logic rd_idle,
                               input logic hold);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= show;
        mode_en_q    = show;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        rx_idle_on <= rx_idle;
        rd_idle_on <= rd_idle;
        if (hold) hold_reqs <= hold_reqs + 1;
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            if (n_err < 40)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            n_err++;
        end
    endtask

    // byte sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else if (rx_ch.valid && !rx_fire) begin
            // item still on offer
        end else if (rx_gap > 0) begin
            rx_ch.valid <= 1'b0;
            rx_gap      <= rx_gap - 1;
        end else if (byte_q.size() > 0) begin
            rx_ch.valid <= 1'b1;
            rx_ch.data  <= t_rx_item'(byte_q.pop_front());
            rx_gap      <= (rx_idle_on && $urandom_range(0, 2) == 0) ? idle_span() : 0;
        end else begin
            rx_ch.valid <= 1'b0;
        end
    end

    // accepted bytes feed the local decode
    always @(posedge i_clk) begin
        rx_fire <= i_rst_n && rx_ch.valid && rx_ch.ready;
        if (i_rst_n && rx_ch.valid && rx_ch.ready) begin
            absorb_byte(rx_ch.data.rx_byte);
            n_taken++;
        end
    end

    // reading receiver: random stalls plus the requested long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rd_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rd_ch.ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_done != hold_reqs) begin
            rd_ch.ready <= 1'b0;
            holds_done  <= holds_done + 1;
            hold_left   <= HOLD_CYCLES;
        end else if (rd_gap > 0) begin
            rd_ch.ready <= 1'b0;
            rd_gap      <= rd_gap - 1;
        end else begin
            rd_ch.ready <= 1'b1;
            if (rd_idle_on && $urandom_range(0, 3) == 0) rd_gap <= idle_span();
        end
    end

    // compare each reading with the oldest one predicted
    always @(posedge i_clk) begin
        if (i_rst_n && rd_ch.valid && rd_ch.ready) begin
            if (readings_q.size() == 0) begin
                if (n_err < 40)
                    $display("%0t: reading mismatch: expected none, actual %p", $time, rd_ch.data);
                n_err++;
            end else begin
                want_rd = readings_q.pop_front();
                check_field("reading_value", $signed(want_rd.reading_value),
                            $signed(rd_ch.data.reading_value));
                check_field("decimal_places", want_rd.decimal_places, rd_ch.data.decimal_places);
                check_field("overload", want_rd.overload, rd_ch.data.overload);
                check_field("prefix_code", want_rd.prefix_code, rd_ch.data.prefix_code);
                check_field("unit_code", want_rd.unit_code, rd_ch.data.unit_code);
                check_field("mode_code", want_rd.mode_code, rd_ch.data.mode_code);
            end
        end
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // stimulus sequence
    initial begin
        int unsigned start;
        int unsigned r;
        rx_ch.valid = 1'b0;
        rx_ch.data  = '0;
        rd_ch.ready = 1'b0;
        foreach (frame_store[i]) frame_store[i] = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: largest negative value with every status bit set
        begin_phase(1'b1, 1'b1, 1'b1, 1'b0);
        put(8'h30);
        repeat (4) put(8'hFF);
        put(FN_VOLT);
        put(8'hFF);
        put(NEWLINE_BYTE);
        // newline alone: lands in the range position, rest of the frame is stale
        put(NEWLINE_BYTE);
        // zero reading, rpm top range, frame closed by the byte limit
        put(8'h35);
        repeat (4) put(8'h30);
        put(FN_FREQ);
        put(8'h00);
        repeat (MAX_FRAME_BYTES - KEPT_BYTES) put(8'h80);

        // random phases; phase 5 holds off the receiver while bytes keep coming
        for (int p = 1; p <= N_PHASES; p++) begin
            begin_phase(p[0], !(p inside {3, 5, 7}), !(p inside {3, 5, 6}), p == 5);
            start = n_pushed;
            while (n_pushed - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 75)      send_reading();
                else if (r < 85) send_short();
                else if (r < 93) send_noise();
                else             send_overrun();
            end
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (n_err == 0 && readings_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
